FILE: rtl/bta_pkg.sv
package bta_pkg;

    localparam int HEAP_BYTES_DEF = 65536;
    localparam int TAG_W = 32;
    localparam int HS_W = 17;
    localparam int RS_W = 17;
    localparam int ADDR_W = 16;
    localparam int SZ_W = 18;
    localparam logic [TAG_W-1:0] SENTINEL = '1;
    localparam logic [HS_W-1:0] HEAP_SIZE_RST = 17'd65536;

    localparam logic [1:0] FN_ALLOC = 2'd0;
    localparam logic [1:0] FN_FREE = 2'd1;
    localparam logic [1:0] FN_FORMAT = 2'd2;
    localparam logic [1:0] FN_UNUSED = 2'd3;

    typedef enum logic [1:0] {
        ST_OK,
        ST_ZERO,
        ST_NOFIT,
        ST_NULL
    } t_stat;

    typedef enum logic [4:0] {
        S_INIT,
        S_CLR,
        S_FHDR,
        S_FFTR,
        S_FSENT,
        S_IDLE,
        S_DISP,
        S_ARD,
        S_ACHK,
        S_AW0,
        S_AW1,
        S_AW2,
        S_AW3,
        S_FR1,
        S_FR2,
        S_FR3,
        S_FW0,
        S_FW1,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        R_WALK,
        R_FSZ,
        R_BTAG,
        R_ATAG
    } t_rsel;

    typedef enum logic [3:0] {
        W_CLR,
        W_FMT_HDR,
        W_FMT_FTR,
        W_FMT_SENT,
        W_UNS_HDR,
        W_UNS_FTR,
        W_SPL_FTR,
        W_SPL_NHDR,
        W_SPL_NFTR,
        W_SPL_HDR,
        W_FREE0,
        W_FREE1
    } t_wsel;

    typedef struct packed {
        logic  load;
        logic  rd_en;
        t_rsel rd_sel;
        logic  wr_en;
        t_wsel wr_sel;
        logic  step;
        logic  cap_t;
        logic  cap_fsz;
        logic  cap_btag;
        logic  cap_atag;
        logic  clr_start;
        logic  clr_inc;
        logic  out_load;
        t_stat stat;
        logic  grant;
    } t_cmd;

    typedef struct packed {
        logic [1:0] func;
        logic       size_zero;
        logic       addr_null;
        logic       fmt_small;
        logic       fit;
        logic       sent;
        logic       steps_over;
        logic       split;
        logic       clr_last;
        logic       out_busy;
    } t_sts;

endpackage

FILE: rtl/bta_req_if.sv
interface bta_req_if;
    import bta_pkg::*;
    logic              valid;
    logic              ready;
    logic [1:0]        func;
    logic [RS_W-1:0]   request_size;
    logic [ADDR_W-1:0] block_address;

    modport source(output valid, func, request_size, block_address, input ready);
    modport sink(input valid, func, request_size, block_address, output ready);
endinterface

FILE: rtl/bta_rsp_if.sv
interface bta_rsp_if;
    import bta_pkg::*;
    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic [ADDR_W-1:0] granted_address;

    modport source(output valid, status, granted_address, input ready);
    modport sink(input valid, status, granted_address, output ready);
endinterface

FILE: rtl/boundary_tag_first_fit_allocator.sv
// Boundary-tag first-fit heap allocator.
// Request channel i_req carries func, request_size and block_address; each
// request yields one response on o_rsp with status and granted_address.
// Configuration: i_cfg_wr_en with i_cfg_wr_data writes heap_size, used by the
// next reformat; write it only while the block is idle.
// One request at a time; the tag store is a single-port memory with a
// registered read, which each request uses in these steps:
//   allocate: reads one tag per block visited by the walk, then on a fit
//   writes two tags without a split and four with one
//   free: three tag reads and two writes; zero-size allocate and null free
//   leave the store alone; reformat: clearing pass, then three tag writes
// A response is loaded into an output register when the work ends and is
// held there; a new request is accepted while it waits. A further result waits
// in the controller until o_rsp.ready frees the output register.
// Reset: heap_size returns to 65536 and the store is cleared and formatted as
// one free block; i_req.ready stays low during this pass.
module boundary_tag_first_fit_allocator import bta_pkg::*; #(
    parameter int HEAP_BYTES = HEAP_BYTES_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_wr_en,
    input  logic [HS_W-1:0] i_cfg_wr_data,
    bta_req_if.sink         i_req,
    bta_rsp_if.source       o_rsp
);

    t_cmd cmd;
    t_sts sts;

    bta_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    bta_dp #(.HEAP_BYTES(HEAP_BYTES)) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .i_func            (i_req.func),
        .i_request_size    (i_req.request_size),
        .i_block_address   (i_req.block_address),
        .i_rsp_ready       (o_rsp.ready),
        .o_rsp_valid       (o_rsp.valid),
        .o_status          (o_rsp.status),
        .o_granted_address (o_rsp.granted_address)
    );

`ifndef SYNTHESIS
    a_port_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.rd_en && cmd.wr_en))
        else $error("tag read and write in one cycle");

    a_ready_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.ready |-> !cmd.wr_en && !cmd.out_load)
        else $error("store or output busy while taking a request");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> !(o_rsp.valid && !o_rsp.ready))
        else $error("pending response overwritten");

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |=> !cmd.out_load)
        else $error("two responses in a row for one request");
`endif

endmodule

FILE: rtl/bta_ctrl.sv
module bta_ctrl import bta_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state, n_state;
    t_stat  r_stat, n_stat;
    logic   r_grant, n_grant;
    logic   r_boot, n_boot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_stat  <= ST_OK;
            r_grant <= 1'b0;
            r_boot  <= 1'b1;
        end else begin
            r_state <= n_state;
            r_stat  <= n_stat;
            r_grant <= n_grant;
            r_boot  <= n_boot;
        end
    end

    always_comb begin
        n_state = r_state;
        n_stat  = r_stat;
        n_grant = r_grant;
        n_boot  = r_boot;
        o_cmd   = '0;
        o_cmd.rd_sel = R_WALK;
        o_cmd.wr_sel = W_CLR;
        o_cmd.stat   = r_stat;
        o_cmd.grant  = r_grant;
        o_req_ready  = 1'b0;
        unique case (r_state)
            S_INIT: begin
                o_cmd.clr_start = 1'b1;
                n_state = S_CLR;
            end
            S_CLR: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_sel  = W_CLR;
                o_cmd.clr_inc = 1'b1;
                if (i_sts.clr_last) n_state = S_FHDR;
            end
            S_FHDR: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = W_FMT_HDR;
                n_state = S_FFTR;
            end
            S_FFTR: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = W_FMT_FTR;
                n_state = S_FSENT;
            end
            S_FSENT: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = W_FMT_SENT;
                n_boot  = 1'b0;
                n_state = r_boot ? S_IDLE : S_DONE;
            end
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                n_stat  = ST_OK;
                n_grant = 1'b0;
                case (i_sts.func)
                    FN_ALLOC: begin
                        if (i_sts.size_zero) begin
                            n_stat  = ST_ZERO;
                            n_state = S_DONE;
                        end else begin
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_sel = R_WALK;
                            n_state = S_ACHK;
                        end
                    end
                    FN_FREE: begin
                        if (i_sts.addr_null) begin
                            n_stat  = ST_NULL;
                            n_state = S_DONE;
                        end else begin
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_sel = R_FSZ;
                            n_state = S_FR1;
                        end
                    end
                    FN_FORMAT: begin
                        if (i_sts.fmt_small) begin
                            n_state = S_DONE;
                        end else begin
                            o_cmd.clr_start = 1'b1;
                            n_state = S_CLR;
                        end
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_ARD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = R_WALK;
                n_state = S_ACHK;
            end
            S_ACHK: begin
                if (i_sts.fit) begin
                    if (i_sts.sent) begin
                        n_stat  = ST_NOFIT;
                        n_state = S_DONE;
                    end else begin
                        o_cmd.cap_t = 1'b1;
                        n_state = S_AW0;
                    end
                end else if (i_sts.steps_over) begin
                    n_stat  = ST_NOFIT;
                    n_state = S_DONE;
                end else begin
                    o_cmd.step = 1'b1;
                    n_state = S_ARD;
                end
            end
            S_AW0: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = i_sts.split ? W_SPL_FTR : W_UNS_HDR;
                n_state = S_AW1;
            end
            S_AW1: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = i_sts.split ? W_SPL_NHDR : W_UNS_FTR;
                if (i_sts.split) begin
                    n_state = S_AW2;
                end else begin
                    n_grant = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_AW2: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = W_SPL_NFTR;
                n_state = S_AW3;
            end
            S_AW3: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = W_SPL_HDR;
                n_grant = 1'b1;
                n_state = S_DONE;
            end
            S_FR1: begin
                o_cmd.cap_fsz = 1'b1;
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_sel  = R_BTAG;
                n_state = S_FR2;
            end
            S_FR2: begin
                o_cmd.cap_btag = 1'b1;
                o_cmd.rd_en    = 1'b1;
                o_cmd.rd_sel   = R_ATAG;
                n_state = S_FR3;
            end
            S_FR3: begin
                o_cmd.cap_atag = 1'b1;
                n_state = S_FW0;
            end
            S_FW0: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = W_FREE0;
                n_state = S_FW1;
            end
            S_FW1: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_sel = W_FREE1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_INIT;
        endcase
    end

endmodule

FILE: rtl/bta_dp.sv
module bta_dp import bta_pkg::*; #(
    parameter int HEAP_BYTES = HEAP_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    input  logic              i_cfg_wr_en,
    input  logic [HS_W-1:0]   i_cfg_wr_data,
    input  logic [1:0]        i_func,
    input  logic [RS_W-1:0]   i_request_size,
    input  logic [ADDR_W-1:0] i_block_address,
    input  logic              i_rsp_ready,
    output logic              o_rsp_valid,
    output logic [1:0]        o_status,
    output logic [ADDR_W-1:0] o_granted_address
);

    localparam int NWORDS = HEAP_BYTES / 4;
    localparam int AW = $clog2(NWORDS);
    localparam int HB_W = $clog2(HEAP_BYTES);
    localparam int OFF_W = (HB_W > 16) ? HB_W : 16;
    localparam int SW = (HB_W + 1 > SZ_W) ? HB_W + 1 : SZ_W;
    localparam int STEP_W = $clog2(NWORDS + 2);
    localparam logic [SW-1:0] LIMIT = SW'(HEAP_BYTES) & ~SW'(7);

    logic [TAG_W-1:0]  r_mem [NWORDS];
    logic [TAG_W-1:0]  r_rdata;
    logic [HS_W-1:0]   r_heap_size;
    logic [1:0]        r_func;
    logic [SZ_W-1:0]   r_size;
    logic [ADDR_W-1:0] r_addr;
    logic [OFF_W-1:0]  r_i;
    logic [STEP_W-1:0] r_steps;
    logic [TAG_W-1:0]  r_t, r_fsz, r_btag, r_atag;
    logic [SW-1:0]     r_s;
    logic [AW-1:0]     r_clr;
    logic              r_out_valid;
    logic [1:0]        r_status;
    logic [ADDR_W-1:0] r_grant_addr;

    logic [SZ_W-1:0]   hs_round;
    logic [SW-1:0]     s_fmt;
    logic [TAG_W-1:0]  b, size32, bsz, asz, merged, sum_both, sum_b, sum_a;
    logic [OFF_W-1:0]  b_o, size_o, a_o, ahdr, bhdr, s_o, rd_off, wr_off, grant_o;
    logic              bfree, afree;
    logic [AW-1:0]     rd_idx, wr_idx;
    logic [TAG_W-1:0]  wr_data;

    assign hs_round = ({1'b0, r_heap_size} + SZ_W'(7)) & ~SZ_W'(7);
    assign s_fmt = (SW'(hs_round) > LIMIT) ? LIMIT : SW'(hs_round);

    assign b = r_t & ~TAG_W'(1);
    assign size32 = TAG_W'(r_size);
    assign b_o = b[OFF_W-1:0];
    assign size_o = OFF_W'(r_size);
    assign a_o = OFF_W'(r_addr);
    assign ahdr = a_o + r_fsz[OFF_W-1:0] - OFF_W'(4);
    assign bsz = r_btag & ~TAG_W'(1);
    assign asz = r_atag & ~TAG_W'(1);
    assign bhdr = a_o - bsz[OFF_W-1:0] - OFF_W'(4);
    assign bfree = r_btag[0];
    assign afree = r_atag[0] && (r_atag != SENTINEL);
    assign sum_both = bsz + r_fsz + asz;
    assign sum_b = bsz + r_fsz;
    assign sum_a = asz + r_fsz;
    assign s_o = OFF_W'(r_s);
    assign grant_o = r_i + OFF_W'(4);

    always_comb begin
        if (bfree && afree) merged = sum_both | TAG_W'(1);
        else if (bfree) merged = sum_b | TAG_W'(1);
        else if (afree) merged = sum_a | TAG_W'(1);
        else merged = r_fsz | TAG_W'(1);
    end

    always_comb begin
        unique case (i_cmd.rd_sel)
            R_WALK: rd_off = r_i;
            R_FSZ:  rd_off = a_o - OFF_W'(4);
            R_BTAG: rd_off = a_o - OFF_W'(8);
            R_ATAG: rd_off = ahdr;
            default: rd_off = r_i;
        endcase
    end
    assign rd_idx = rd_off[AW+1:2];

    always_comb begin
        wr_off  = r_i;
        wr_data = '0;
        unique case (i_cmd.wr_sel)
            W_CLR: begin
                wr_off  = '0;
                wr_data = '0;
            end
            W_FMT_HDR: begin
                wr_off  = OFF_W'(4);
                wr_data = TAG_W'(r_s - SW'(8)) | TAG_W'(1);
            end
            W_FMT_FTR: begin
                wr_off  = s_o - OFF_W'(8);
                wr_data = TAG_W'(r_s - SW'(8)) | TAG_W'(1);
            end
            W_FMT_SENT: begin
                wr_off  = s_o - OFF_W'(4);
                wr_data = SENTINEL;
            end
            W_UNS_HDR: begin
                wr_off  = r_i;
                wr_data = b;
            end
            W_UNS_FTR: begin
                wr_off  = r_i + b_o - OFF_W'(4);
                wr_data = b;
            end
            W_SPL_FTR: begin
                wr_off  = r_i + b_o - OFF_W'(4);
                wr_data = (b - size32 - TAG_W'(8)) | TAG_W'(1);
            end
            W_SPL_NHDR: begin
                wr_off  = r_i + size_o + OFF_W'(8);
                wr_data = (b - size32 - TAG_W'(8)) | TAG_W'(1);
            end
            W_SPL_NFTR: begin
                wr_off  = r_i + size_o + OFF_W'(4);
                wr_data = size32 + TAG_W'(8);
            end
            W_SPL_HDR: begin
                wr_off  = r_i;
                wr_data = size32 + TAG_W'(8);
            end
            W_FREE0: begin
                wr_off  = bfree ? bhdr : a_o - OFF_W'(4);
                wr_data = merged;
            end
            W_FREE1: begin
                wr_off  = (bfree && afree) ? ahdr + asz[OFF_W-1:0] - OFF_W'(4)
                                           : ahdr - OFF_W'(4);
                wr_data = merged;
            end
            default: begin
                wr_off  = r_i;
                wr_data = '0;
            end
        endcase
    end
    assign wr_idx = (i_cmd.wr_sel == W_CLR) ? r_clr : wr_off[AW+1:2];

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) r_mem[wr_idx] <= wr_data;
        if (i_cmd.rd_en) r_rdata <= r_mem[rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_size <= HEAP_SIZE_RST;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) r_heap_size <= i_cfg_wr_data;
            if (i_cmd.clr_start) r_clr <= '0;
            else if (i_cmd.clr_inc) r_clr <= r_clr + AW'(1);
            if (i_cmd.out_load) r_out_valid <= 1'b1;
            else if (i_rsp_ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func  <= i_func;
            r_size  <= ({1'b0, i_request_size} + SZ_W'(7)) & ~SZ_W'(7);
            r_addr  <= i_block_address;
            r_i     <= OFF_W'(4);
            r_steps <= '0;
        end else if (i_cmd.step) begin
            r_i     <= r_i + (r_rdata[OFF_W-1:0] & ~OFF_W'(1));
            r_steps <= r_steps + STEP_W'(1);
        end
        if (i_cmd.cap_t) r_t <= r_rdata;
        if (i_cmd.cap_fsz) r_fsz <= r_rdata & ~TAG_W'(1);
        if (i_cmd.cap_btag) r_btag <= r_rdata;
        if (i_cmd.cap_atag) r_atag <= r_rdata;
        if (i_cmd.clr_start) r_s <= s_fmt;
        if (i_cmd.out_load) begin
            r_status     <= i_cmd.stat;
            r_grant_addr <= i_cmd.grant ? grant_o[ADDR_W-1:0] : '0;
        end
    end

    always_comb begin
        o_sts.func       = r_func;
        o_sts.size_zero  = (r_size == '0);
        o_sts.addr_null  = (r_addr == '0);
        o_sts.fmt_small  = (r_heap_size <= HS_W'(16));
        o_sts.fit        = r_rdata[0] &&
                           ({1'b0, r_rdata & ~TAG_W'(1)} >= ((TAG_W+1)'(r_size) + (TAG_W+1)'(8)));
        o_sts.sent       = (r_rdata == SENTINEL);
        o_sts.steps_over = (r_steps > STEP_W'(NWORDS));
        o_sts.split      = !((b == size32 + TAG_W'(8)) || (b == size32 + TAG_W'(16)));
        o_sts.clr_last   = (r_clr == AW'(NWORDS - 1));
        o_sts.out_busy   = r_out_valid && !i_rsp_ready;
    end

    assign o_rsp_valid       = r_out_valid;
    assign o_status          = r_status;
    assign o_granted_address = r_grant_addr;

endmodule
